### rtl/bdq_pkg.sv
// shared types and codes for the bounded double-ended queue
package bdq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_LEFT  = 3'd0,
    OP_PUSH_RIGHT = 3'd1,
    OP_POP_LEFT   = 3'd2,
    OP_POP_RIGHT  = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // shift and write controls broadcast along the cell row
  typedef struct packed {
    logic push_left;
    logic push_right;
    logic pop_left;
  } cell_ctrl_t;

endpackage

### rtl/bdq_cell.sv
// one storage cell of the queue row, shifting with its neighbours
module bdq_cell (
  input  logic                          clk,
  input  bdq_pkg::cell_ctrl_t           ctrl,
  input  logic                          wr_here,
  input  logic [bdq_pkg::DATA_W-1:0]    left_data,
  input  logic [bdq_pkg::DATA_W-1:0]    right_data,
  input  logic [bdq_pkg::DATA_W-1:0]    push_value,
  output logic [bdq_pkg::DATA_W-1:0]    data_r
);

  logic [bdq_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_left) begin
      data_nxt = left_data;
    end else if (ctrl.push_right && wr_here) begin
      data_nxt = push_value;
    end else if (ctrl.pop_left) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### rtl/bounded_double_ended_queue.sv
// top level of the bounded double-ended queue
//
// usage:
//   in_*  : one item per operation; in_tuser carries the operation code
//           (push left, push right, pop left, pop right, clear) and
//           in_tdata the value to push.
//   out_* : exactly one result item per input item; out_tuser carries
//           the status (done, full, empty), out_tdata the value pushed
//           or popped, zero when refused or on clear.
//   cfg_* : capacity limit write, taken at any cycle; limits above DEPTH
//           act as DEPTH, a limit of zero refuses every push.
// elements live in a row of DEPTH cells, left end in cell 0; left pushes
// and left pops shift the whole row by one cell, right pushes write the first free cell.
// the result register is loaded in the cycle after acceptance; one item
// is taken every cycle while out_tready lets each result leave.
// reset empties the queue and sets the limit to 16. while a result waits
// with out_tready low, no new item is taken; an item is taken in the same
// cycle as the waiting result leaves.
module bounded_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bdq_pkg::DATA_W-1:0]    in_tdata,   // [31:0] push_value
  input  logic [bdq_pkg::OP_W-1:0]      in_tuser,   // [2:0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bdq_pkg::DATA_W-1:0]    out_tdata,  // [31:0] data_out
  output logic [bdq_pkg::STAT_W-1:0]    out_tuser,  // [1:0] status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdq_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > bdq_pkg::LIMIT_W) ? CW : bdq_pkg::LIMIT_W;

  logic [CW-1:0]                  count_r, count_nxt;
  logic [bdq_pkg::LIMIT_W-1:0]    limit_r, limit_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bdq_pkg::status_t               out_status_r, out_status_nxt;
  logic [bdq_pkg::DATA_W-1:0]     out_data_r, out_data_nxt;

  logic                           accept;
  logic                           is_full;
  logic                           is_empty;
  logic [CW-1:0]                  tail_idx;
  logic [bdq_pkg::DATA_W-1:0]     tail_data;
  bdq_pkg::cell_ctrl_t            ctrl;
  bdq_pkg::op_t                   op;
  logic [bdq_pkg::DATA_W-1:0]     cell_data [DEPTH];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  assign op       = bdq_pkg::op_t'(in_tuser);
  assign is_full  = (CMPW'(count_r) >= CMPW'(limit_r)) || (count_r >= CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign tail_idx = count_r - CW'(1);

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [bdq_pkg::DATA_W-1:0] left_d;
    logic [bdq_pkg::DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_tdata;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    bdq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_here    (count_r == CW'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .push_value (in_tdata),
      .data_r     (cell_data[i])
    );
  end

  // right end element, picked by the one cell that matches the tail
  always_comb begin
    tail_data = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | (cell_data[i] & {bdq_pkg::DATA_W{tail_idx == CW'(i)}});
    end
  end

  always_comb begin
    ctrl           = '0;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    limit_nxt      = cfg_valid ? cfg_data : limit_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = bdq_pkg::ST_DONE;
      out_data_nxt   = '0;
      unique case (op) inside
        bdq_pkg::OP_PUSH_LEFT, bdq_pkg::OP_PUSH_RIGHT: begin
          if (is_full) begin
            out_status_nxt = bdq_pkg::ST_FULL;
          end else begin
            ctrl.push_left  = (op == bdq_pkg::OP_PUSH_LEFT);
            ctrl.push_right = (op == bdq_pkg::OP_PUSH_RIGHT);
            count_nxt       = count_r + CW'(1);
            out_data_nxt    = in_tdata;
          end
        end
        bdq_pkg::OP_POP_LEFT: begin
          if (is_empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            ctrl.pop_left = 1'b1;
            count_nxt     = count_r - CW'(1);
            out_data_nxt  = cell_data[0];
          end
        end
        bdq_pkg::OP_POP_RIGHT: begin
          if (is_empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            count_nxt    = count_r - CW'(1);
            out_data_nxt = tail_data;
          end
        end
        bdq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      limit_r     <= bdq_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_full && (op == bdq_pkg::OP_PUSH_LEFT || op == bdq_pkg::OP_PUSH_RIGHT)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not grow the queue");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == bdq_pkg::OP_CLEAR |=> count_r == '0 && out_data_r == '0)
    else $error("clear left elements behind");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != bdq_pkg::ST_DONE |-> out_data_r == '0)
    else $error("refused item carries data");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule

### tb/bdq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// expected-result tracking for the bounded double-ended queue testbench
package bdq_scoreboard_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  // op codes with no operation behind them
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    bdq_pkg::status_t           status;
    logic [bdq_pkg::DATA_W-1:0] value;
  } deque_result_t;

  class deque_scoreboard;
    logic [bdq_pkg::DATA_W-1:0]  slots [QUEUE_DEPTH];
    logic [3:0]                  head;
    logic [bdq_pkg::LIMIT_W-1:0] count;
    logic [bdq_pkg::LIMIT_W-1:0] limit;
    deque_result_t               awaited [$];
    int unsigned                 mismatches;

    function void reset_state();
      head = '0;
      count = '0;
      limit = bdq_pkg::LIMIT_RESET;
      awaited.delete();
      mismatches = 0;
    endfunction

    function void set_limit(logic [bdq_pkg::LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // works out the result of one accepted item and moves the queue state on
    function void note_item(logic [bdq_pkg::OP_W-1:0] op,
                            logic [bdq_pkg::DATA_W-1:0] value);
      deque_result_t res;
      int unsigned   cap;
      res.status = bdq_pkg::ST_DONE;
      res.value = '0;
      cap = (limit > QUEUE_DEPTH) ? QUEUE_DEPTH : limit;
      case (op) inside
        bdq_pkg::OP_PUSH_LEFT, bdq_pkg::OP_PUSH_RIGHT: begin
          if (count >= cap) begin
            res.status = bdq_pkg::ST_FULL;
          end else begin
            if (op == bdq_pkg::OP_PUSH_LEFT) begin
              head = head - 4'd1;
              slots[head] = value;
            end else begin
              slots[head + count[3:0]] = value;
            end
            count = count + 1'b1;
            res.value = value;
          end
        end
        bdq_pkg::OP_POP_LEFT: begin
          if (count == 0) begin
            res.status = bdq_pkg::ST_EMPTY;
          end else begin
            res.value = slots[head];
            head = head + 4'd1;
            count = count - 1'b1;
          end
        end
        bdq_pkg::OP_POP_RIGHT: begin
          if (count == 0) begin
            res.status = bdq_pkg::ST_EMPTY;
          end else begin
            // a full ring wraps count to zero in four bits, which still lands right
            res.value = slots[head + count[3:0] - 4'd1];
            count = count - 1'b1;
          end
        end
        bdq_pkg::OP_CLEAR: begin
          head = '0;
          count = '0;
        end
        default: begin
        end
      endcase
      awaited.insert(awaited.size(), res);
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(logic [bdq_pkg::STAT_W-1:0] status,
                      logic [bdq_pkg::DATA_W-1:0] value);
      deque_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result status %0d data %h with nothing awaited", status, value));
      end else begin
        want = awaited[0];
        awaited.delete(0);
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (value !== want.value)
          report($sformatf("data %h, expected %h", value, want.value));
      end
    endtask
  endclass

endpackage

### tb/bounded_double_ended_queue_test.sv
`timescale 1ns / 100ps
// testbench top for the bounded double-ended queue
module bounded_double_ended_queue_test;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 120;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 72;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [bdq_pkg::DATA_W-1:0]   in_tdata = '0;
  logic [bdq_pkg::OP_W-1:0]     in_tuser = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [bdq_pkg::DATA_W-1:0]   out_tdata;
  logic [bdq_pkg::STAT_W-1:0]   out_tuser;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bdq_pkg::LIMIT_W-1:0]  cfg_data = '0;

  bdq_scoreboard_pkg::deque_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  bit              hold_req = 1'b0;
  int unsigned     quiet_cycles = 0;

  bounded_double_ended_queue #(
    .DEPTH(bdq_scoreboard_pkg::QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [bdq_pkg::OP_W-1:0] op,
                           input logic [bdq_pkg::DATA_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering items and wait until every awaited result is back
  task automatic settle();
    in_tvalid <= 1'b0;
    // wait for the monitor to note the last accepted item first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bdq_pkg::LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [bdq_pkg::OP_W-1:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return bdq_pkg::OP_CLEAR;
    if (r < 6)
      return bdq_pkg::OP_W'($urandom_range(bdq_scoreboard_pkg::OP_SPARE_FIRST,
                                           bdq_scoreboard_pkg::OP_SPARE_LAST));
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? bdq_pkg::OP_PUSH_LEFT : bdq_pkg::OP_PUSH_RIGHT;
    return $urandom_range(1) ? bdq_pkg::OP_POP_LEFT : bdq_pkg::OP_POP_RIGHT;
  endfunction

  function automatic logic [bdq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned phase_limit [PHASES];
    int unsigned phase_push [PHASES];
    int unsigned phase_send_idle [PHASES];
    int unsigned phase_recv_stall [PHASES];
    int          phase;

    phase_limit      = '{31, 4, 16, 0, 9, 16};
    phase_push       = '{65, 50, 60, 40, 50, 55};
    phase_send_idle  = '{0, 65, 0, 33, 33, 0};
    phase_recv_stall = '{0, 0, 65, 33, 33, 0};
    phase_limit[4] = $urandom_range(1, 15);

    sb = new();
    sb.reset_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, extreme values at both ends, spare codes, clear
    send_item(bdq_pkg::OP_POP_LEFT, 32'h1234_5678);
    send_item(bdq_pkg::OP_POP_RIGHT, 32'h8765_4321);
    send_item(bdq_pkg::OP_PUSH_LEFT, 32'h7fff_ffff);
    send_item(bdq_pkg::OP_PUSH_RIGHT, 32'h8000_0000);
    send_item(bdq_pkg::OP_PUSH_LEFT, 32'hffff_ffff);
    send_item(bdq_pkg::OP_PUSH_RIGHT, 32'h0000_0000);
    send_item(bdq_pkg::OP_POP_LEFT, 32'h0);
    send_item(bdq_pkg::OP_POP_RIGHT, 32'h0);
    send_item(bdq_scoreboard_pkg::OP_SPARE_FIRST, 32'hdead_beef);
    send_item(bdq_pkg::OP_W'(bdq_scoreboard_pkg::OP_SPARE_FIRST + 1), 32'h5555_aaaa);
    send_item(bdq_scoreboard_pkg::OP_SPARE_LAST, 32'hffff_ffff);
    send_item(bdq_pkg::OP_CLEAR, 32'hcafe_f00d);
    send_item(bdq_pkg::OP_POP_LEFT, 32'h0);
    send_item(bdq_pkg::OP_PUSH_RIGHT, 32'h0000_0042);

    // limit of one with the queue already holding one element
    settle();
    write_limit(5'd1);
    send_item(bdq_pkg::OP_PUSH_LEFT, 32'h0000_0099);
    send_item(bdq_pkg::OP_POP_RIGHT, 32'h0);
    send_item(bdq_pkg::OP_PUSH_RIGHT, 32'h0000_0077);

    // limit of zero below the count: pushes refused, stored element still pops
    settle();
    write_limit(5'd0);
    send_item(bdq_pkg::OP_PUSH_LEFT, 32'h0000_0011);
    send_item(bdq_pkg::OP_PUSH_RIGHT, 32'h0000_0022);
    send_item(bdq_pkg::OP_POP_LEFT, 32'h0);
    send_item(bdq_pkg::OP_POP_RIGHT, 32'h0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      write_limit(bdq_pkg::LIMIT_W'(phase_limit[phase]));
      send_idle_pct = phase_send_idle[phase];
      recv_stall_pct = phase_recv_stall[phase];
      // last phase: long hold-off on the result side while items keep coming
      if (phase == PHASES - 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(pick_op(phase_push[phase]), pick_value());
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
